// ===== design/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared token kinds, error codes, character codes and character classes
// for the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int MAX_RES = 3;

    localparam logic [4:0] K_INT     = 5'd0;
    localparam logic [4:0] K_FLOAT   = 5'd1;
    localparam logic [4:0] K_STRING  = 5'd2;
    localparam logic [4:0] K_IDENT   = 5'd3;
    localparam logic [4:0] K_ADD     = 5'd4;
    localparam logic [4:0] K_ADD_EQ  = 5'd5;
    localparam logic [4:0] K_DIV     = 5'd6;
    localparam logic [4:0] K_MUL     = 5'd7;
    localparam logic [4:0] K_MOD     = 5'd8;
    localparam logic [4:0] K_CARET   = 5'd9;
    localparam logic [4:0] K_SUB     = 5'd10;
    localparam logic [4:0] K_SUB_EQ  = 5'd11;
    localparam logic [4:0] K_NOT     = 5'd12;
    localparam logic [4:0] K_QUEST   = 5'd13;
    localparam logic [4:0] K_ASSIGN  = 5'd14;
    localparam logic [4:0] K_EQ      = 5'd15;
    localparam logic [4:0] K_NE      = 5'd16;
    localparam logic [4:0] K_GT      = 5'd17;
    localparam logic [4:0] K_LT      = 5'd18;
    localparam logic [4:0] K_GE      = 5'd19;
    localparam logic [4:0] K_LE      = 5'd20;
    localparam logic [4:0] K_LPAREN  = 5'd21;
    localparam logic [4:0] K_RPAREN  = 5'd22;
    localparam logic [4:0] K_LBRACE  = 5'd23;
    localparam logic [4:0] K_RBRACE  = 5'd24;
    localparam logic [4:0] K_COMMA   = 5'd25;
    localparam logic [4:0] K_SEMI    = 5'd26;
    localparam logic [4:0] K_ERROR   = 5'd27;
    localparam logic [4:0] K_END     = 5'd28;

    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_SYMBOL  = 3'd1;
    localparam logic [2:0] E_FLOAT   = 3'd2;
    localparam logic [2:0] E_NEWLINE = 3'd3;
    localparam logic [2:0] E_ESCAPE  = 3'd4;
    localparam logic [2:0] E_UNTERM  = 3'd5;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_BANG      = 8'h21;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_0         = 8'h30;
    localparam logic [7:0] CH_9         = 8'h39;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_LT        = 8'h3C;
    localparam logic [7:0] CH_EQUAL     = 8'h3D;
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_QUEST     = 8'h3F;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_UNDERLINE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;

    function automatic logic is_decimal(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_id_start(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_UNDERLINE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_oper_start(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_BANG) ||
               (c == CH_EQUAL) || (c == CH_LT) || (c == CH_GT);
    endfunction

    function automatic logic is_escape_char(input logic [7:0] c);
        return (c == CH_BACKSLASH) || (c == CH_QUOTE) || (c == CH_LOWER_N);
    endfunction

    // zero when c is not a one-character token
    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            CH_STAR:    k = K_MUL;
            CH_SLASH:   k = K_DIV;
            CH_LPAREN:  k = K_LPAREN;
            CH_RPAREN:  k = K_RPAREN;
            CH_LBRACE:  k = K_LBRACE;
            CH_RBRACE:  k = K_RBRACE;
            CH_PERCENT: k = K_MOD;
            CH_CARET:   k = K_CARET;
            CH_SEMI:    k = K_SEMI;
            CH_COMMA:   k = K_COMMA;
            CH_QUEST:   k = K_QUEST;
            default:    k = K_INT;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] oper_kind(input logic [7:0] c, input logic doubled);
        logic [4:0] k;
        case (c)
            CH_PLUS:  k = doubled ? K_ADD_EQ : K_ADD;
            CH_MINUS: k = doubled ? K_SUB_EQ : K_SUB;
            CH_BANG:  k = doubled ? K_NE     : K_NOT;
            CH_EQUAL: k = doubled ? K_EQ     : K_ASSIGN;
            CH_LT:    k = doubled ? K_LE     : K_LT;
            default:  k = doubled ? K_GE     : K_GT;
        endcase
        return k;
    endfunction

endpackage

// ===== design/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: one source byte per beat in, tokens and error items out.
// ----------------------------------------------------------------------------
// Usage:
//   Source channel: byte_value, last_byte with src_valid / src_stall. A zero
//   byte or a beat with last_byte set closes the text; an end item follows.
//   Token channel: one result per beat with tok_valid / tok_stall;
//   last_result marks the final result caused by a source byte.
//   Order: a byte is registered on accept and scanned from that register;
//   its results are written into the result queue and offered from the
//   queue head, and the scan waits while the queue is nearly full.
//   Throughput: one byte per cycle while the 8-entry result queue has room
//   for three more results; a byte yields zero to three results, and the
//   token side drains one per cycle while tok_stall is low, so the
//   sustained input rate is the output rate divided by results per byte.
//   Reset: scanner idle at offset 0, line 1, column 1, queue empty, error
//   flag clear. After the end item all further bytes are consumed silently.
//   A stall on the token side holds the queue head; once the queue is
//   nearly full src_stall rises and the pending byte waits in its register.
// ----------------------------------------------------------------------------
module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     src_valid,
    output logic                     src_stall,
    input  logic [7:0]               byte_value,
    input  logic                     last_byte,
    output logic                     tok_valid,
    input  logic                     tok_stall,
    output logic [4:0]               token_kind,
    output logic [POSITION_BITS-1:0] start_offset,
    output logic [POSITION_BITS-1:0] token_length,
    output logic [POSITION_BITS-1:0] token_line,
    output logic [POSITION_BITS-1:0] token_column,
    output logic [2:0]               error_code,
    output logic                     any_error,
    output logic                     last_result
);

    localparam int DEPTH    = 8;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    localparam logic [3:0] M_IDLE     = 4'd0;
    localparam logic [3:0] M_IDENT    = 4'd1;
    localparam logic [3:0] M_NUMBER   = 4'd2;
    localparam logic [3:0] M_DOT      = 4'd3;
    localparam logic [3:0] M_FRACTION = 4'd4;
    localparam logic [3:0] M_STR_BODY = 4'd5;
    localparam logic [3:0] M_ESCAPE   = 4'd6;
    localparam logic [3:0] M_COMMENT  = 4'd7;
    localparam logic [3:0] M_OPER     = 4'd8;
    localparam logic [3:0] M_DONE     = 4'd9;

    localparam logic [POSITION_BITS-1:0] POS_ZERO = '0;
    localparam logic [POSITION_BITS-1:0] POS_ONE  = POSITION_BITS'(1);
    localparam logic [POSITION_BITS-1:0] POS_TWO  = POSITION_BITS'(2);
    localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;

    typedef struct packed {
        logic [4:0]               kind;
        logic [POSITION_BITS-1:0] start;
        logic [POSITION_BITS-1:0] len;
        logic [POSITION_BITS-1:0] line;
        logic [POSITION_BITS-1:0] col;
        logic [2:0]               err;
        logic                     any;
        logic                     last;
    } result_t;

    function automatic result_t mk(
        input logic [4:0]               kind,
        input logic [POSITION_BITS-1:0] start,
        input logic [POSITION_BITS-1:0] len,
        input logic [POSITION_BITS-1:0] line,
        input logic [POSITION_BITS-1:0] col,
        input logic [2:0]               err
    );
        result_t r;
        r.kind  = kind;
        r.start = start;
        r.len   = len;
        r.line  = line;
        r.col   = col;
        r.err   = err;
        r.any   = 1'b0;
        r.last  = 1'b0;
        return r;
    endfunction

    logic                     in_valid_reg;
    logic [7:0]               in_byte_reg;
    logic                     in_last_reg;

    logic [3:0]               mode_reg,      mode_next;
    logic [7:0]               pend_reg,      pend_next;
    logic [POSITION_BITS-1:0] cur_off_reg,   cur_off_next;
    logic [POSITION_BITS-1:0] cur_line_reg,  cur_line_next;
    logic [POSITION_BITS-1:0] cur_col_reg,   cur_col_next;
    logic [POSITION_BITS-1:0] tok_start_reg, tok_start_next;
    logic [POSITION_BITS-1:0] st_line_reg,   st_line_next;
    logic [POSITION_BITS-1:0] st_col_reg,    st_col_next;
    logic                     err_seen_reg,  err_seen_next;

    result_t                  queue_mem [DEPTH];
    logic [PTR_BITS-1:0]      head_reg;
    logic [PTR_BITS-1:0]      tail_reg;
    logic [CNT_BITS-1:0]      count_reg;

    result_t                  slot [MAX_RES];
    logic [1:0]               slot_n;
    logic [1:0]               push_n;
    logic                     proc_ok;
    logic                     process;
    logic                     step_en;
    logic                     src_take;
    logic                     tok_take;
    result_t                  head_res;

    assign proc_ok   = count_reg <= CNT_BITS'(DEPTH - MAX_RES);
    assign process   = in_valid_reg && proc_ok;
    assign step_en   = process && (mode_reg != M_DONE);
    assign push_n    = step_en ? slot_n : 2'd0;
    assign src_stall = in_valid_reg && !proc_ok;
    assign src_take  = src_valid && !src_stall;
    assign tok_valid = count_reg != '0;
    assign tok_take  = tok_valid && !tok_stall;

    // scan one byte: close / begin / end-of-text candidates, then pack
    always_comb
    begin
        logic [7:0]               c;
        logic                     fin;
        logic                     do_begin;
        logic                     flag;
        logic [3:0]               m_eff;
        logic [POSITION_BITS-1:0] span_o;
        logic [POSITION_BITS-1:0] span_n;
        logic [POSITION_BITS-1:0] esc_col;
        logic [POSITION_BITS-1:0] esc_col_n;
        result_t                  cand [5];
        logic [4:0]               cand_v;
        result_t                  r;

        c        = in_byte_reg;
        fin      = (c == CH_NUL) || in_last_reg;
        do_begin = 1'b0;
        m_eff    = (mode_reg > M_DONE) ? M_IDLE : mode_reg;
        cand_v   = '0;
        r        = '0;
        for (int i = 0; i < 5; i++)
        begin
            cand[i] = '0;
        end

        mode_next      = m_eff;
        pend_next      = pend_reg;
        tok_start_next = tok_start_reg;
        st_line_next   = st_line_reg;
        st_col_next    = st_col_reg;
        cur_off_next   = cur_off_reg;
        cur_line_next  = cur_line_reg;
        cur_col_next   = cur_col_reg;

        span_o  = cur_off_reg - tok_start_reg;
        esc_col = (cur_col_reg > POS_ONE) ? cur_col_reg - POS_ONE : POS_ONE;

        if (c != CH_NUL)
        begin
            unique case (m_eff)
                M_IDENT:
                begin
                    if (!(is_id_start(c) || is_decimal(c)))
                    begin
                        cand_v[0] = 1'b1;
                        cand[0]   = mk(K_IDENT, tok_start_reg, span_o, st_line_reg,
                                       st_col_reg, E_NONE);
                        do_begin  = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    if (c == CH_DOT)
                    begin
                        mode_next = M_DOT;
                    end
                    else if (!is_decimal(c))
                    begin
                        cand_v[0] = 1'b1;
                        cand[0]   = mk(K_INT, tok_start_reg, span_o, st_line_reg,
                                       st_col_reg, E_NONE);
                        do_begin  = 1'b1;
                    end
                end
                M_DOT:
                begin
                    if (is_decimal(c))
                    begin
                        mode_next = M_FRACTION;
                    end
                    else
                    begin
                        cand_v[0] = 1'b1;
                        cand[0]   = mk(K_ERROR, tok_start_reg, span_o, st_line_reg,
                                       st_col_reg, E_FLOAT);
                        do_begin  = 1'b1;
                    end
                end
                M_FRACTION:
                begin
                    if (!is_decimal(c))
                    begin
                        cand_v[0] = 1'b1;
                        cand[0]   = mk(K_FLOAT, tok_start_reg, span_o, st_line_reg,
                                       st_col_reg, E_NONE);
                        do_begin  = 1'b1;
                    end
                end
                M_STR_BODY:
                begin
                    if (c == CH_QUOTE)
                    begin
                        cand_v[0] = 1'b1;
                        cand[0]   = mk(K_STRING, tok_start_reg + POS_ONE, span_o - POS_ONE,
                                       st_line_reg, st_col_reg, E_NONE);
                        mode_next = M_IDLE;
                    end
                    else if (c == CH_BACKSLASH)
                    begin
                        mode_next = M_ESCAPE;
                    end
                    else if (c == CH_LF)
                    begin
                        cand_v[0] = 1'b1;
                        cand[0]   = mk(K_ERROR, cur_off_reg, POS_ONE, cur_line_reg,
                                       cur_col_reg, E_NEWLINE);
                    end
                end
                M_ESCAPE:
                begin
                    if (!is_escape_char(c))
                    begin
                        cand_v[0] = 1'b1;
                        cand[0]   = mk(K_ERROR, cur_off_reg - POS_ONE, POS_TWO, cur_line_reg,
                                       esc_col, E_ESCAPE);
                    end
                    mode_next = M_STR_BODY;
                end
                M_COMMENT:
                begin
                    if (c == CH_LF)
                    begin
                        mode_next = M_IDLE;
                    end
                end
                M_OPER:
                begin
                    cand_v[0] = 1'b1;
                    if (c == CH_EQUAL)
                    begin
                        cand[0]   = mk(oper_kind(pend_reg, 1'b1), tok_start_reg, POS_TWO,
                                       st_line_reg, st_col_reg, E_NONE);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        cand[0]   = mk(oper_kind(pend_reg, 1'b0), tok_start_reg, POS_ONE,
                                       st_line_reg, st_col_reg, E_NONE);
                        do_begin  = 1'b1;
                    end
                end
                default:
                begin
                    do_begin = 1'b1;
                end
            endcase

            if (do_begin)
            begin
                mode_next      = M_IDLE;
                tok_start_next = cur_off_reg;
                st_line_next   = cur_line_reg;
                st_col_next    = cur_col_reg;
                if (is_space(c))
                begin
                    mode_next = M_IDLE;
                end
                else if (is_decimal(c))
                begin
                    mode_next = M_NUMBER;
                end
                else if (is_id_start(c))
                begin
                    mode_next = M_IDENT;
                end
                else if (c == CH_QUOTE)
                begin
                    mode_next = M_STR_BODY;
                end
                else if (c == CH_HASH)
                begin
                    mode_next = M_COMMENT;
                end
                else if (is_oper_start(c))
                begin
                    pend_next = c;
                    mode_next = M_OPER;
                end
                else
                begin
                    cand_v[1] = 1'b1;
                    if (single_kind(c) != K_INT)
                    begin
                        cand[1] = mk(single_kind(c), cur_off_reg, POS_ONE, cur_line_reg,
                                     cur_col_reg, E_NONE);
                    end
                    else
                    begin
                        cand[1] = mk(K_ERROR, cur_off_reg, POS_ONE, cur_line_reg,
                                     cur_col_reg, E_SYMBOL);
                    end
                end
            end

            cur_off_next = cur_off_reg + POS_ONE;
            if (c == CH_LF)
            begin
                cur_col_next  = POS_ONE;
                cur_line_next = (cur_line_reg < POS_MAX) ? cur_line_reg + POS_ONE
                                                         : cur_line_reg;
            end
            else
            begin
                cur_col_next = (cur_col_reg < POS_MAX) ? cur_col_reg + POS_ONE
                                                       : cur_col_reg;
            end
        end

        span_n    = cur_off_next - tok_start_next;
        esc_col_n = (cur_col_next > POS_ONE) ? cur_col_next - POS_ONE : POS_ONE;

        if (fin)
        begin
            unique case (mode_next)
                M_IDENT:
                begin
                    cand_v[2] = 1'b1;
                    cand[2]   = mk(K_IDENT, tok_start_next, span_n, st_line_next,
                                   st_col_next, E_NONE);
                end
                M_NUMBER:
                begin
                    cand_v[2] = 1'b1;
                    cand[2]   = mk(K_INT, tok_start_next, span_n, st_line_next,
                                   st_col_next, E_NONE);
                end
                M_DOT:
                begin
                    cand_v[2] = 1'b1;
                    cand[2]   = mk(K_ERROR, tok_start_next, span_n, st_line_next,
                                   st_col_next, E_FLOAT);
                end
                M_FRACTION:
                begin
                    cand_v[2] = 1'b1;
                    cand[2]   = mk(K_FLOAT, tok_start_next, span_n, st_line_next,
                                   st_col_next, E_NONE);
                end
                M_STR_BODY:
                begin
                    cand_v[3] = 1'b1;
                    cand[3]   = mk(K_ERROR, tok_start_next, span_n, st_line_next,
                                   st_col_next, E_UNTERM);
                end
                M_ESCAPE:
                begin
                    cand_v[2] = 1'b1;
                    cand[2]   = mk(K_ERROR, cur_off_next - POS_ONE, POS_ONE, cur_line_next,
                                   esc_col_n, E_ESCAPE);
                    cand_v[3] = 1'b1;
                    cand[3]   = mk(K_ERROR, tok_start_next, span_n, st_line_next,
                                   st_col_next, E_UNTERM);
                end
                M_OPER:
                begin
                    cand_v[2] = 1'b1;
                    cand[2]   = mk(oper_kind(pend_next, 1'b0), tok_start_next, POS_ONE,
                                   st_line_next, st_col_next, E_NONE);
                end
                default:
                begin
                end
            endcase
            cand_v[4] = 1'b1;
            cand[4]   = mk(K_END, cur_off_next, POS_ZERO, cur_line_next, cur_col_next,
                           E_NONE);
            mode_next = M_DONE;
        end

        // pack in order, sticky flag carried through
        flag   = err_seen_reg;
        slot_n = 2'd0;
        for (int i = 0; i < MAX_RES; i++)
        begin
            slot[i] = '0;
        end
        for (int i = 0; i < 5; i++)
        begin
            if (cand_v[i] && (slot_n != 2'd3))
            begin
                r            = cand[i];
                flag         = flag || (r.err != E_NONE);
                r.any        = flag;
                slot[slot_n] = r;
                slot_n       = slot_n + 2'd1;
            end
        end
        if (slot_n != 2'd0)
        begin
            slot[slot_n - 2'd1].last = 1'b1;
        end
        err_seen_next = flag;
    end

    always_ff @(posedge clk)
    begin
        if (src_take)
        begin
            in_byte_reg <= byte_value;
            in_last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (2'(i) < push_n)
            begin
                queue_mem[tail_reg + PTR_BITS'(i)] <= slot[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mode_reg      <= M_IDLE;
            pend_reg      <= '0;
            cur_off_reg   <= '0;
            cur_line_reg  <= POS_ONE;
            cur_col_reg   <= POS_ONE;
            tok_start_reg <= '0;
            st_line_reg   <= POS_ONE;
            st_col_reg    <= POS_ONE;
            err_seen_reg  <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (src_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (process)
            begin
                in_valid_reg <= 1'b0;
            end

            if (step_en)
            begin
                mode_reg      <= mode_next;
                pend_reg      <= pend_next;
                cur_off_reg   <= cur_off_next;
                cur_line_reg  <= cur_line_next;
                cur_col_reg   <= cur_col_next;
                tok_start_reg <= tok_start_next;
                st_line_reg   <= st_line_next;
                st_col_reg    <= st_col_next;
                err_seen_reg  <= err_seen_next;
            end

            tail_reg  <= tail_reg + PTR_BITS'(push_n);
            if (tok_take)
            begin
                head_reg <= head_reg + PTR_BITS'(1);
            end
            count_reg <= count_reg + CNT_BITS'(push_n) - CNT_BITS'(tok_take);
        end
    end

    assign head_res     = queue_mem[head_reg];
    assign token_kind   = head_res.kind;
    assign start_offset = head_res.start;
    assign token_length = head_res.len;
    assign token_line   = head_res.line;
    assign token_column = head_res.col;
    assign error_code   = head_res.err;
    assign any_error    = head_res.any;
    assign last_result  = head_res.last;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("result queue overflow");

    a_silent_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_DONE) |-> (push_n == 2'd0))
        else $error("result produced after end of text");

    a_sticky_error: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_take && any_error) |=> (!tok_valid || any_error))
        else $error("error flag dropped");

    a_error_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && (error_code != E_NONE)) |-> (token_kind == K_ERROR && any_error))
        else $error("error code on a non-error beat");

endmodule
